// ===== design/qrs_pkg.sv =====
package qrs_pkg;

	// default structural parameters
	localparam int HP_WINDOW_DEF     = 5;
	localparam int LP_WINDOW_DEF     = 30;
	localparam int THRESH_WINDOW_DEF = 250;
	localparam int RAND_RANGE_DEF    = 1024;

	// field and register widths
	localparam int SAMPLE_W   = 10;
	localparam int DRAW_W     = 10;
	localparam int GAIN_W     = 16;
	localparam int HOLD_W     = 10;
	localparam int DATA_W     = 32;
	localparam int HP_W       = 16;
	localparam int SQ_W       = 23;
	localparam int ALPHA_W    = 13;
	localparam int MUL_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// forgetting factor range in Q0.16
	localparam int ALPHA_MIN  = 655;
	localparam int ALPHA_SPAN = 5898;

	// register reset values
	localparam logic [GAIN_W-1:0] HP_GAIN_RST     = 16'd13107;
	localparam logic [GAIN_W-1:0] PEAK_WEIGHT_RST = 16'd11469;
	localparam logic [HOLD_W-1:0] HOLDOFF_RST     = 10'd100;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HP_GAIN     = 2'd0,
		CFG_PEAK_WEIGHT = 2'd1,
		CFG_HOLDOFF     = 2'd2
	} cfg_idx_t;

	// input and result payloads
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [DRAW_W-1:0]   rand_draw;
	} item_t;

	typedef struct packed {
		logic              beat_flag;
		logic [DATA_W-1:0] energy;
		logic [DATA_W-1:0] threshold_now;
	} result_t;

	// operand pairs of the shared multiplier
	typedef enum logic [2:0] {
		MUL_OLD   = 3'd0,
		MUL_HP    = 3'd1,
		MUL_ALPHA = 3'd2,
		MUL_SQ    = 3'd3,
		MUL_AG    = 3'd4,
		MUL_PEAK  = 3'd5,
		MUL_THR   = 3'd6
	} mul_sel_t;

	// controller to datapath
	typedef struct packed {
		mul_sel_t mul_sel;
		logic     take_item;
		logic     save_old;
		logic     form_hp;
		logic     push_hp;
		logic     acc_energy;
		logic     decide;
		logic     clear_peak;
		logic     save_a;
		logic     set_thr;
		logic     load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic upd;
		logic out_free;
	} status_t;

endpackage

// ===== design/qrs_ctrl.sv =====
module qrs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  qrs_pkg::status_t  status,
	output qrs_pkg::cmd_t     cmd
);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_HPM  = 10'b0000000010,
		ST_HPV  = 10'b0000000100,
		ST_SQR  = 10'b0000001000,
		ST_ACC  = 10'b0000010000,
		ST_DEC  = 10'b0000100000,
		ST_UPA  = 10'b0001000000,
		ST_UPB  = 10'b0010000000,
		ST_UPC  = 10'b0100000000,
		ST_DONE = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	// only the idle state takes an item
	assign sample_stall = (state_q != ST_IDLE);

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = qrs_pkg::MUL_OLD;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					cmd.take_item = 1'b1;
					state_d       = ST_HPM;
				end
			end
			ST_HPM: begin
				cmd.mul_sel  = qrs_pkg::MUL_HP;
				cmd.save_old = 1'b1;
				state_d      = ST_HPV;
			end
			ST_HPV: begin
				cmd.mul_sel = qrs_pkg::MUL_ALPHA;
				cmd.form_hp = 1'b1;
				state_d     = ST_SQR;
			end
			ST_SQR: begin
				cmd.mul_sel = qrs_pkg::MUL_SQ;
				cmd.push_hp = 1'b1;
				state_d     = ST_ACC;
			end
			ST_ACC: begin
				cmd.mul_sel    = qrs_pkg::MUL_AG;
				cmd.acc_energy = 1'b1;
				state_d        = ST_DEC;
			end
			ST_DEC: begin
				cmd.decide = 1'b1;
				if (status.upd) begin
					state_d = ST_UPA;
				end else if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_UPA: begin
				cmd.mul_sel    = qrs_pkg::MUL_PEAK;
				cmd.clear_peak = 1'b1;
				state_d        = ST_UPB;
			end
			ST_UPB: begin
				cmd.mul_sel = qrs_pkg::MUL_THR;
				cmd.save_a  = 1'b1;
				state_d     = ST_UPC;
			end
			ST_UPC: begin
				cmd.set_thr = 1'b1;
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== design/qrs_dp.sv =====
module qrs_dp #(
	parameter int HP_WINDOW     = qrs_pkg::HP_WINDOW_DEF,
	parameter int LP_WINDOW     = qrs_pkg::LP_WINDOW_DEF,
	parameter int THRESH_WINDOW = qrs_pkg::THRESH_WINDOW_DEF,
	parameter int RAND_RANGE    = qrs_pkg::RAND_RANGE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [qrs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [qrs_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  qrs_pkg::item_t                    item,
	input  qrs_pkg::cmd_t                     cmd,
	output qrs_pkg::status_t                  status,
	input  logic                              result_stall,
	output logic                              result_valid,
	output qrs_pkg::result_t                  result_item
);

	localparam int SMP_MAX = (1 << qrs_pkg::SAMPLE_W) - 1;
	localparam int SUM_W   = $clog2(HP_WINDOW * SMP_MAX + 1);
	localparam int SUMX_W  = SUM_W + 1;
	localparam int CTR_W   = $clog2(THRESH_WINDOW + 1);
	localparam int CENTER  = (HP_WINDOW + 1) / 2;
	localparam int R_MAX   = RAND_RANGE - 1;
	localparam int ALPHA_K = qrs_pkg::DRAW_W + $clog2(RAND_RANGE);
	// ceiling reciprocal, exact floor of r*span/range for every draw
	localparam logic [63:0] ALPHA_F =
		((64'(qrs_pkg::ALPHA_SPAN) << ALPHA_K) + 64'(RAND_RANGE) - 64'd1) / 64'(RAND_RANGE);

	typedef logic [qrs_pkg::DRAW_W-1:0]  draw_t;
	typedef logic [qrs_pkg::ALPHA_W-1:0] alpha_t;
	typedef logic [CTR_W-1:0]            ctr_t;
	typedef logic [SUMX_W-1:0]           sumx_t;

	function automatic logic [qrs_pkg::HP_W-1:0] mag(input logic signed [qrs_pkg::HP_W-1:0] v);
		return v[qrs_pkg::HP_W-1] ? (~v + 16'd1) : v;
	endfunction

	// configuration registers
	logic [qrs_pkg::GAIN_W-1:0] gain_q, pw_q;
	logic [qrs_pkg::HOLD_W-1:0] hold_q;

	// filter state
	logic [qrs_pkg::SAMPLE_W-1:0]    smp_q [HP_WINDOW];
	logic [SUM_W-1:0]                hsum_q;
	logic signed [qrs_pkg::HP_W-1:0] hpl_q [LP_WINDOW];
	logic [qrs_pkg::DATA_W-1:0]      energy_q, thr_q, peak_q;
	ctr_t                            warm_q, widx_q;
	logic                            hold_act_q;
	logic [qrs_pkg::HOLD_W-1:0]      hold_cnt_q;

	// working registers
	draw_t                           draw_q;
	logic [63:0]                     prod_q;
	logic [qrs_pkg::SQ_W-1:0]        oldsq_q;
	logic signed [qrs_pkg::HP_W-1:0] hp_q;
	alpha_t                          alpha_q;
	logic [28:0]                     ag_q;
	logic [qrs_pkg::DATA_W-1:0]      ev_q, a_q;
	logic                            det_q;
	logic                            result_valid_q;
	qrs_pkg::result_t                result_q;

	// warm-up flags
	logic warm_hp, warm_lp, warm_thr;
	assign warm_hp  = 32'(warm_q) >= HP_WINDOW;
	assign warm_lp  = 32'(warm_q) >= LP_WINDOW;
	assign warm_thr = 32'(warm_q) < THRESH_WINDOW;

	// running sample sum on transfer
	sumx_t sum_new;
	assign sum_new = sumx_t'(hsum_q) + sumx_t'(item.sample)
		- (warm_hp ? sumx_t'(smp_q[HP_WINDOW-1]) : sumx_t'(0));

	// high-pass value from gain product
	logic [32:0]                     scl_t;
	logic [20:0]                     scaled;
	logic signed [22:0]              hp_diff;
	logic signed [qrs_pkg::HP_W-1:0] hp_next;
	assign scl_t   = {1'b0, prod_q[31:0]} + 33'd2048;
	assign scaled  = scl_t[32:12];
	assign hp_diff = $signed({9'b0, smp_q[CENTER], 4'b0}) - $signed({2'b0, scaled});
	always_comb begin
		if (!warm_hp) begin
			hp_next = '0;
		end else if (hp_diff > 23'sd32767) begin
			hp_next = 16'sh7FFF;
		end else if (hp_diff < -23'sd32768) begin
			hp_next = 16'sh8000;
		end else begin
			hp_next = hp_diff[qrs_pkg::HP_W-1:0];
		end
	end

	// rounded square
	logic [31:0]              sq_t;
	logic [qrs_pkg::SQ_W-1:0] sq_units;
	assign sq_t     = {1'b0, prod_q[30:0]} + 32'd128;
	assign sq_units = sq_t[30:8];

	// windowed energy
	logic [32:0]                s1, s2;
	logic [qrs_pkg::DATA_W-1:0] e_new;
	assign s1 = {1'b0, energy_q} + 33'(sq_units);
	always_comb begin
		if (!warm_lp) begin
			s2 = s1;
		end else if (s1 > 33'(oldsq_q)) begin
			s2 = s1 - 33'(oldsq_q);
		end else begin
			s2 = '0;
		end
	end
	assign e_new = s2[32] ? '1 : s2[31:0];

	// detection and window bookkeeping
	logic [qrs_pkg::DATA_W-1:0] thr1, peak1;
	logic [qrs_pkg::HOLD_W-1:0] cnt1, cnt_n;
	logic                       act1, fire, upd;
	assign thr1  = (warm_thr && (ev_q > thr_q)) ? ev_q : thr_q;
	assign peak1 = (ev_q > peak_q) ? ev_q : peak_q;
	assign cnt1  = hold_cnt_q + 10'd1;
	always_comb begin
		act1  = hold_act_q;
		cnt_n = hold_cnt_q;
		if (hold_act_q) begin
			if (cnt1 >= hold_q) begin
				act1  = 1'b0;
				cnt_n = '0;
			end else begin
				cnt_n = cnt1;
			end
		end
	end
	assign fire = (ev_q > thr1) && !act1;
	assign upd  = !fire && (32'(widx_q) >= THRESH_WINDOW);

	// threshold update terms
	logic [63:0]                ra_t, rb_t;
	logic [32:0]                t_sum;
	logic [qrs_pkg::DATA_W-1:0] thr_new;
	assign ra_t    = prod_q + 64'h8000_0000;
	assign rb_t    = prod_q + 64'h8000;
	assign t_sum   = {1'b0, a_q} + {1'b0, rb_t[47:16]};
	assign thr_new = t_sum[32] ? '1 : t_sum[31:0];

	// clamped draw
	draw_t r_cl;
	assign r_cl = (32'(draw_q) > R_MAX) ? draw_t'(R_MAX) : draw_q;

	// shared multiplier operand select
	logic [qrs_pkg::MUL_W-1:0] mul_a, mul_b;
	always_comb begin
		unique case (cmd.mul_sel)
			qrs_pkg::MUL_OLD: begin
				mul_a = 32'(mag(hpl_q[LP_WINDOW-1]));
				mul_b = 32'(mag(hpl_q[LP_WINDOW-1]));
			end
			qrs_pkg::MUL_HP: begin
				mul_a = 32'(gain_q);
				mul_b = 32'(hsum_q);
			end
			qrs_pkg::MUL_ALPHA: begin
				mul_a = 32'(r_cl);
				mul_b = ALPHA_F[31:0];
			end
			qrs_pkg::MUL_SQ: begin
				mul_a = 32'(mag(hp_q));
				mul_b = 32'(mag(hp_q));
			end
			qrs_pkg::MUL_AG: begin
				mul_a = 32'(alpha_q);
				mul_b = 32'(pw_q);
			end
			qrs_pkg::MUL_PEAK: begin
				mul_a = 32'(ag_q);
				mul_b = peak_q;
			end
			qrs_pkg::MUL_THR: begin
				mul_a = 32'(17'h10000 - 17'(alpha_q));
				mul_b = thr_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	logic [63:0] prod_d;
	assign prod_d = 64'(mul_a) * 64'(mul_b);

	// working registers, no reset
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (cmd.take_item) begin
			draw_q <= item.rand_draw;
		end
		if (cmd.save_old) begin
			oldsq_q <= sq_units;
		end
		if (cmd.form_hp) begin
			hp_q <= hp_next;
		end
		if (cmd.push_hp) begin
			alpha_q <= alpha_t'(qrs_pkg::ALPHA_MIN) + prod_q[ALPHA_K +: qrs_pkg::ALPHA_W];
		end
		if (cmd.acc_energy) begin
			ev_q <= warm_lp ? e_new : '0;
		end
		if (cmd.decide) begin
			ag_q  <= prod_q[28:0];
			det_q <= fire;
		end
		if (cmd.save_a) begin
			a_q <= ra_t[63:32];
		end
		if (cmd.load_out) begin
			result_q.beat_flag     <= cmd.decide ? fire : det_q;
			result_q.energy        <= ev_q;
			result_q.threshold_now <= cmd.set_thr ? thr_new : (cmd.decide ? thr1 : thr_q);
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= qrs_pkg::HP_GAIN_RST;
			pw_q   <= qrs_pkg::PEAK_WEIGHT_RST;
			hold_q <= qrs_pkg::HOLDOFF_RST;
		end else if (cfg_valid) begin
			unique case (qrs_pkg::cfg_idx_t'(cfg_index))
				qrs_pkg::CFG_HP_GAIN:     gain_q <= cfg_data;
				qrs_pkg::CFG_PEAK_WEIGHT: pw_q   <= cfg_data;
				qrs_pkg::CFG_HOLDOFF:     hold_q <= cfg_data[qrs_pkg::HOLD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HP_WINDOW; i++) begin
				smp_q[i] <= '0;
			end
			for (int i = 0; i < LP_WINDOW; i++) begin
				hpl_q[i] <= '0;
			end
			hsum_q     <= '0;
			energy_q   <= '0;
			thr_q      <= '0;
			peak_q     <= '0;
			warm_q     <= '0;
			widx_q     <= '0;
			hold_act_q <= 1'b0;
			hold_cnt_q <= '0;
		end else begin
			// sample line and running sum on transfer
			if (cmd.take_item) begin
				smp_q[0] <= item.sample;
				for (int i = 1; i < HP_WINDOW; i++) begin
					smp_q[i] <= smp_q[i-1];
				end
				hsum_q <= sum_new[SUM_W-1:0];
			end
			// high-pass delay line
			if (cmd.push_hp) begin
				hpl_q[0] <= hp_q;
				for (int i = 1; i < LP_WINDOW; i++) begin
					hpl_q[i] <= hpl_q[i-1];
				end
			end
			if (cmd.acc_energy) begin
				energy_q <= e_new;
			end
			if (cmd.decide) begin
				if (warm_thr) begin
					warm_q <= warm_q + ctr_t'(1);
				end
				thr_q      <= thr1;
				peak_q     <= peak1;
				hold_act_q <= act1 | fire;
				hold_cnt_q <= cnt_n;
				if (!fire) begin
					widx_q <= upd ? ctr_t'(0) : widx_q + ctr_t'(1);
				end
			end
			if (cmd.clear_peak) begin
				peak_q <= '0;
			end
			if (cmd.set_thr) begin
				thr_q <= thr_new;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign status.upd      = upd;
	assign status.out_free = !result_valid_q || !result_stall;
	assign result_valid    = result_valid_q;
	assign result_item     = result_q;

endmodule

// ===== design/qrs_beat_detector_unit.sv =====
// QRS beat detector: one ECG sample in, one result out per sample.
// sample channel: sample_item carries a 10-bit sample and a 10-bit random
//   draw; a transfer happens when sample_valid is high and sample_stall low.
// result channel: result_item carries the detection flag, the windowed
//   energy and the threshold after this sample; same valid/stall transfer.
// cfg channel: cfg_index selects hp_gain, peak_weight or holdoff_samples,
//   written with cfg_data when cfg_valid is high; cfg_ready is always high.
//   Write only while no sample is in flight.
// Timing: one sample at a time through a single shared 32x32 multiplier.
//   A sample runs through the states HPM, HPV, SQR, ACC and DEC to the result
//   register; a sample that closes a threshold window also runs UPA, UPB and
//   UPC for two more products and their sum. A new sample is taken only in
//   idle, after the result of the last one has been loaded.
// Reset: arst_n clears all filter lines, sums, threshold and counters and
//   loads the register defaults; no clearing pass is needed.
// Stall: the result register holds while result_stall is high; a new sample
//   is still taken and runs until its result is ready, then waits.
module qrs_beat_detector_unit #(
	parameter int HP_WINDOW     = qrs_pkg::HP_WINDOW_DEF,
	parameter int LP_WINDOW     = qrs_pkg::LP_WINDOW_DEF,
	parameter int THRESH_WINDOW = qrs_pkg::THRESH_WINDOW_DEF,
	parameter int RAND_RANGE    = qrs_pkg::RAND_RANGE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  qrs_pkg::item_t                 sample_item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output qrs_pkg::result_t               result_item,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [qrs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [qrs_pkg::CFG_DATA_W-1:0] cfg_data
);

	qrs_pkg::cmd_t    cmd;
	qrs_pkg::status_t status;

	assign cfg_ready = 1'b1;

	// sequencer
	qrs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// filters, multiplier and output register
	qrs_dp #(
		.HP_WINDOW     (HP_WINDOW),
		.LP_WINDOW     (LP_WINDOW),
		.THRESH_WINDOW (THRESH_WINDOW),
		.RAND_RANGE    (RAND_RANGE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item         (sample_item),
		.cmd          (cmd),
		.status       (status),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result_item  (result_item)
	);

endmodule

// ===== bench/qrs_checker.sv =====
`timescale 1ns / 100ps

module qrs_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	input  logic                            sample_stall,
	input  qrs_pkg::item_t                  sample_item,
	input  logic                            result_valid,
	input  logic                            result_stall,
	input  qrs_pkg::result_t                result_item,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [qrs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [qrs_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              errors,
	output int                              pending,
	output int                              results_seen,
	output int                              beats_seen
);

	localparam int HP_N = qrs_pkg::HP_WINDOW_DEF;
	localparam int LP_N = qrs_pkg::LP_WINDOW_DEF;
	localparam int TW   = qrs_pkg::THRESH_WINDOW_DEF;
	localparam int RR   = qrs_pkg::RAND_RANGE_DEF;

	localparam int SAMPLE_W = qrs_pkg::SAMPLE_W;
	localparam int DRAW_W   = qrs_pkg::DRAW_W;
	localparam int GAIN_W   = qrs_pkg::GAIN_W;
	localparam int HOLD_W   = qrs_pkg::HOLD_W;
	localparam int HP_W     = qrs_pkg::HP_W;
	localparam int DATA_W   = qrs_pkg::DATA_W;

	// register copies
	logic [GAIN_W-1:0] gain;
	logic [GAIN_W-1:0] weight;
	logic [HOLD_W-1:0] hold_len;

	// filter and threshold state
	logic [SAMPLE_W-1:0]   smp_line [0:HP_N];
	int unsigned           hp_sum;
	logic signed [HP_W-1:0] hp_line [0:LP_N];
	logic [DATA_W-1:0]     energy_acc;
	logic [7:0]            warm_cnt;
	logic [DATA_W-1:0]     thr;
	logic [DATA_W-1:0]     peak;
	logic [7:0]            win_idx;
	logic                  hold_on;
	logic [HOLD_W-1:0]     hold_cnt;

	qrs_pkg::result_t results_due [$];
	int      mismatch_count;
	int      result_count;
	int      beat_count;

	function automatic void clear_state();
		gain       = qrs_pkg::HP_GAIN_RST;
		weight     = qrs_pkg::PEAK_WEIGHT_RST;
		hold_len   = qrs_pkg::HOLDOFF_RST;
		hp_sum     = 0;
		energy_acc = '0;
		warm_cnt   = '0;
		thr        = '0;
		peak       = '0;
		win_idx    = '0;
		hold_on    = 1'b0;
		hold_cnt   = '0;
		for (int i = 0; i <= HP_N; i++)
			smp_line[i] = '0;
		for (int i = 0; i <= LP_N; i++)
			hp_line[i] = '0;
	endfunction

	// squared high-pass value in integer units
	function automatic logic [DATA_W-1:0] hp_power(logic signed [HP_W-1:0] v);
		longint mag;
		mag = v;
		if (mag < 0)
			mag = -mag;
		return DATA_W'((mag * mag + 128) >> 8);
	endfunction

	// threshold pulled toward the weighted window peak
	function automatic logic [DATA_W-1:0] forget_threshold(logic [DRAW_W-1:0] draw);
		longint unsigned r, alpha, part_peak, part_old, total;
		r = draw;
		if (r > RR - 1)
			r = RR - 1;
		alpha     = qrs_pkg::ALPHA_MIN + (r * qrs_pkg::ALPHA_SPAN) / RR;
		part_peak = (alpha * 64'(weight) * 64'(peak) + 64'h8000_0000) >> 32;
		part_old  = ((64'd65536 - alpha) * 64'(thr) + 64'h8000) >> 16;
		total     = part_peak + part_old;
		return (total > 64'hFFFF_FFFF) ? '1 : total[DATA_W-1:0];
	endfunction

	// one sample through high-pass, energy window, threshold and hold-off
	function automatic qrs_pkg::result_t detect_beat(logic [SAMPLE_W-1:0] smp,
			logic [DRAW_W-1:0] draw);
		qrs_pkg::result_t res;
		logic signed [HP_W-1:0] hp;
		longint          center, scaled, diff;
		longint unsigned acc, drop;
		logic [DATA_W-1:0] ev;

		// high-pass over the sample line
		for (int i = HP_N; i > 0; i--)
			smp_line[i] = smp_line[i-1];
		smp_line[0] = smp;
		hp_sum = hp_sum + smp;
		if (warm_cnt < HP_N) begin
			hp = '0;
		end else begin
			hp_sum = hp_sum - smp_line[HP_N];
			center = longint'(smp_line[(HP_N + 1) / 2]) * 16;
			scaled = longint'((64'(gain) * 64'(hp_sum) + 64'd2048) >> 12);
			diff   = center - scaled;
			if (diff > 32767)
				diff = 32767;
			if (diff < -32768)
				diff = -32768;
			hp = HP_W'(diff);
		end

		// windowed energy
		for (int i = LP_N; i > 0; i--)
			hp_line[i] = hp_line[i-1];
		hp_line[0] = hp;
		acc = 64'(energy_acc) + 64'(hp_power(hp));
		if (warm_cnt >= LP_N) begin
			drop = hp_power(hp_line[LP_N]);
			acc  = (acc > drop) ? acc - drop : 64'd0;
		end
		energy_acc = (acc > 64'hFFFF_FFFF) ? '1 : acc[DATA_W-1:0];
		ev = (warm_cnt < LP_N) ? '0 : energy_acc;

		// first window: threshold follows the largest energy
		if (warm_cnt < TW) begin
			if (ev > thr)
				thr = ev;
			warm_cnt = warm_cnt + 8'd1;
		end

		// hold-off after a beat
		if (hold_on) begin
			hold_cnt = hold_cnt + 1'b1;
			if (hold_cnt >= hold_len) begin
				hold_on  = 1'b0;
				hold_cnt = '0;
			end
		end

		if (ev > peak)
			peak = ev;

		// beat, or window bookkeeping
		if (ev > thr && !hold_on) begin
			hold_on = 1'b1;
			res.beat_flag = 1'b1;
		end else begin
			if (win_idx >= TW) begin
				thr     = forget_threshold(draw);
				win_idx = '0;
				peak    = '0;
			end else begin
				win_idx = win_idx + 8'd1;
			end
			res.beat_flag = 1'b0;
		end
		res.energy        = ev;
		res.threshold_now = thr;
		return res;
	endfunction

	function automatic void flag_result(string what, qrs_pkg::result_t want,
			qrs_pkg::result_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t %s: expected beat %0b energy %0d thr %0d, got beat %0b energy %0d thr %0d",
				$time, what, want.beat_flag, want.energy, want.threshold_now,
				got.beat_flag, got.energy, got.threshold_now);
	endfunction

	// watch all three channels
	always @(posedge clk or negedge arst_n) begin
		qrs_pkg::result_t want;
		if (!arst_n) begin
			clear_state();
			results_due.delete();
			mismatch_count = 0;
			result_count   = 0;
			beat_count     = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (qrs_pkg::cfg_idx_t'(cfg_index))
					qrs_pkg::CFG_HP_GAIN:     gain     = cfg_data;
					qrs_pkg::CFG_PEAK_WEIGHT: weight   = cfg_data;
					qrs_pkg::CFG_HOLDOFF:     hold_len = cfg_data[HOLD_W-1:0];
					default: ;
				endcase
			end
			if (sample_valid && !sample_stall)
				results_due.push_back(detect_beat(sample_item.sample, sample_item.rand_draw));
			if (result_valid && !result_stall) begin
				result_count++;
				if (result_item.beat_flag === 1'b1)
					beat_count++;
				if (results_due.size() == 0) begin
					flag_result("unexpected result", '0, result_item);
				end else begin
					want = results_due.pop_front();
					if (want.beat_flag !== result_item.beat_flag
							|| want.energy !== result_item.energy
							|| want.threshold_now !== result_item.threshold_now)
						flag_result("mismatch", want, result_item);
				end
			end
		end
		errors       <= mismatch_count;
		pending      <= results_due.size();
		results_seen <= result_count;
		beats_seen   <= beat_count;
	end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_ITEMS  = 370;
	localparam int LONG_HOLD    = 400;

	localparam int SAMPLE_W = qrs_pkg::SAMPLE_W;
	localparam int DRAW_W   = qrs_pkg::DRAW_W;

	logic                           clk          = 1'b0;
	logic                           arst_n       = 1'b0;
	logic                           sample_valid = 1'b0;
	logic                           sample_stall;
	qrs_pkg::item_t                 sample_item  = '0;
	logic                           result_valid;
	logic                           result_stall = 1'b0;
	qrs_pkg::result_t               result_item;
	logic                           cfg_valid    = 1'b0;
	logic                           cfg_ready;
	logic [qrs_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [qrs_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

	int errors, pending, results_seen, beats_seen;
	int items_sent    = 0;
	int setting_count = 0;
	int cycle_count   = 0;

	always #5 clk = ~clk;

	qrs_beat_detector_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_item  (sample_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	qrs_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_item  (sample_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.pending      (pending),
		.results_seen (results_seen),
		.beats_seen   (beats_seen)
	);

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// one sample transfer after a random gap, or with no gap in every fourth run of 128 samples
	task automatic send_item(logic [SAMPLE_W-1:0] smp, logic [DRAW_W-1:0] draw);
		int             gap;
		qrs_pkg::item_t it;
		gap = ((items_sent / 128) % 4 == 2) ? 0 : $urandom_range(15, 0);
		it.sample    = smp;
		it.rand_draw = draw;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_item  <= it;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		items_sent++;
	endtask

	// wait until every result is back, then idle before going on
	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write all three registers back to back
	task automatic set_config(logic [15:0] gain, logic [15:0] weight, logic [15:0] hold);
		cfg_valid <= 1'b1;
		cfg_index <= qrs_pkg::CFG_HP_GAIN;
		cfg_data  <= gain;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= qrs_pkg::CFG_PEAK_WEIGHT;
		cfg_data  <= weight;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= qrs_pkg::CFG_HOLDOFF;
		cfg_data  <= hold;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		setting_count++;
	endtask

	// synthetic heart rhythm with occasional bursts of wideband noise
	task automatic run_rhythm(int count);
		int beat_left  = 0;
		int noise_left = 0;
		int amp        = 0;
		int base       = 512;
		int v;
		for (int n = 0; n < count; n++) begin
			if (noise_left == 0 && $urandom_range(39, 0) == 0)
				noise_left = $urandom_range(30, 3);
			if (noise_left > 0) begin
				noise_left--;
				v = $urandom_range(1023, 0);
			end else begin
				if (beat_left == 0) begin
					beat_left = $urandom_range(260, 60);
					amp       = $urandom_range(480, 120);
					base      = $urandom_range(620, 380);
				end
				beat_left--;
				v = base + int'($urandom_range(24, 0)) - 12;
				case (beat_left)
					3: v = v + amp / 4;
					2: v = v + amp;
					1: v = v - amp / 2;
					default: ;
				endcase
				if (v < 0)
					v = 0;
				if (v > 1023)
					v = 1023;
			end
			send_item(SAMPLE_W'(v), DRAW_W'($urandom_range(1023, 0)));
		end
		sample_valid <= 1'b0;
	endtask

	// result side: random stalls, one long hold-off so the input backs up
	initial begin
		int stall_n;
		int taken;
		taken = 0;
		@(posedge clk);
		forever begin
			if (taken == 300)
				stall_n = LONG_HOLD;
			else if ((taken / 100) % 4 == 1)
				stall_n = 0;
			else
				stall_n = $urandom_range(15, 0);
			if (stall_n > 0) begin
				result_stall <= 1'b1;
				repeat (stall_n) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
			taken++;
		end
	end

	// stimulus and verdict
	initial begin
		logic [SAMPLE_W-1:0] smp;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes and walking bits under reset settings, through the high-pass warm-up
		for (int i = 0; i < 24; i++) begin
			case (i % 4)
				0: smp = '0;
				1: smp = '1;
				2: smp = SAMPLE_W'(1 << (i % SAMPLE_W));
				default: smp = ~SAMPLE_W'(1 << (i % SAMPLE_W));
			endcase
			send_item(smp, (i % 3 == 0) ? '0 : (i % 3 == 1) ? '1 : DRAW_W'(1 << (i % DRAW_W)));
		end
		sample_valid <= 1'b0;
		drain();

		// full gain and weight, longest hold-off
		set_config(16'hFFFF, 16'hFFFF, 16'd1023);
		run_rhythm(PHASE_ITEMS);
		drain();

		// zero gain and weight; hold-off zero through ignored upper bits
		set_config(16'h0000, 16'h0000, 16'hFC00);
		run_rhythm(PHASE_ITEMS);
		drain();

		// default filter, shortest hold-off
		set_config(qrs_pkg::HP_GAIN_RST, qrs_pkg::PEAK_WEIGHT_RST, 16'd1);
		run_rhythm(PHASE_ITEMS);
		drain();

		// random settings
		set_config(16'($urandom), 16'($urandom), 16'($urandom));
		run_rhythm(PHASE_ITEMS);

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d samples sent over %0d register settings, %0d results checked",
			items_sent, setting_count + 1, results_seen);
		$display("%0d beats flagged, %0d mismatches", beats_seen, errors);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
design/qrs_pkg.sv
design/qrs_ctrl.sv
design/qrs_dp.sv
design/qrs_beat_detector_unit.sv
bench/qrs_checker.sv
bench/testbench.sv
